FILE: hw/rtl/vector_command_executor_core_macros.svh
// assertion macros for the vector command executor
// used by vector_command_executor_core; expects clk and rst_n in scope
`ifndef VECTOR_COMMAND_EXECUTOR_CORE_MACROS_SVH
`define VECTOR_COMMAND_EXECUTOR_CORE_MACROS_SVH

// same-cycle implication
`define VCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vce_pkg.sv
// shared types, constants and helpers for the vector command executor
// no dependencies; imported by every module of the block except vce_ram
package vce_pkg;

  // memory geometry; depth must be a power of two
  localparam int MEM_DEPTH      = 1024;
  localparam int WORD_BITS      = 32;
  localparam int ADDR_W         = $clog2(MEM_DEPTH);
  localparam int SMALL_MAT_SIZE = 2;
  localparam int LARGE_MAT_SIZE = 3;
  localparam int VCOPY_DEPTH    = 3;
  localparam int VIDX_W         = $clog2(VCOPY_DEPTH);
  localparam int CNT_W          = 11;
  localparam int FADDR_W        = 10;
  localparam int VALUE_W        = 32;
  localparam int SUM_W          = (ADDR_W > CNT_W) ? ADDR_W : CNT_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MV2   = 3'd2,
    OP_MV3   = 3'd3,
    OP_WRITE = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EW_RDA,
    S_EW_RDB,
    S_EW_WR,
    S_CP_RD,
    S_CP_WR,
    S_MV_RDM,
    S_MV_RDA,
    S_MV_WR,
    S_WORD_WR,
    S_WORD_RD,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    WSEL_SUM,
    WSEL_DIFF,
    WSEL_MACC,
    WSEL_ZERO,
    WSEL_WORD
  } wsel_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic               right_to_left;
    logic [CNT_W-1:0]   element_count;
    logic [FADDR_W-1:0] first_source;
    logic [FADDR_W-1:0] second_source;
    logic [FADDR_W-1:0] destination;
    logic [VALUE_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               was_read;
  } out_item_t;

  typedef struct packed {
    logic              re;
    addr_t             raddr;
    logic              we;
    addr_t             waddr;
    wsel_e             wsel;
    logic              cap_op;
    logic              use_mul;
    logic              cap_vcopy;
    logic [VIDX_W-1:0] vidx;
    logic              out_load;
    logic              out_is_read;
  } ctl_t;

  // base plus offset, wrapped to the memory depth
  function automatic addr_t wrap_addr(input cnt_t base, input cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    return addr_t'(s);
  endfunction

endpackage

FILE: hw/rtl/vector_command_executor_core.sv
// Vector command executor. Runs one command per input item against a
// word memory with one read port and one write port (registered read) and
// returns one result item per command. Add/subtract need two reads on the
// one read port and one write per element; matvec first copies the vector
// and clears the destination, then reads a matrix word and the partial sum
// and writes the new sum back for each product; word write and word read
// make one memory access each. Overlapping regions see earlier writes
// because every access finishes before the next one is issued. The memory
// has no reset; reading an unwritten word returns whatever it holds. A
// finished result sits in an output register while the next item is taken.
// Depends on vce_pkg, vce_ram, vce_ctrl, vce_dp and the macros header.
`include "vector_command_executor_core_macros.svh"

module vector_command_executor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vce_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output vce_pkg::out_item_t out_item
);
  import vce_pkg::*;

  ctl_t      ctl;
  in_item_t  cmd;
  word_t     rdata;
  word_t     wdata;
  logic      out_free;
  logic      out_valid_r;
  out_item_t out_item_r;

  assign out_free = !out_valid_r || !out_stall;

  vce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_free (out_free),
    .cmd      (cmd),
    .ctl      (ctl)
  );

  vce_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .write_value (cmd.write_value),
    .rdata       (rdata),
    .wdata       (wdata)
  );

  vce_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (ctl.waddr),
    .wdata (wdata),
    .re    (ctl.re),
    .raddr (ctl.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_item_r.was_read   <= ctl.out_is_read;
      out_item_r.read_value <= ctl.out_is_read ? VALUE_W'(rdata) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `VCE_ASSERT_NOW(ast_no_rw_overlap, ctl.re, !ctl.we, "read and write issued together")
  `VCE_ASSERT_NEXT(ast_busy_after_accept, in_valid && !in_stall, in_stall,
                   "item accepted while previous command still runs")
  `VCE_ASSERT_NOW(ast_write_when_busy, ctl.we, in_stall, "memory write while idle")
  `VCE_ASSERT_NOW(ast_load_when_free, ctl.out_load, !out_valid || !out_stall,
                  "result overwrites an item not yet taken")

endmodule

FILE: hw/rtl/vce_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module vce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/vce_ctrl.sv
// command sequencer: fsm, element and row/col counters, memory addresses
// depends on vce_pkg
module vce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  vce_pkg::in_item_t in_item,
  output logic              in_stall,
  input  logic              out_free,
  output vce_pkg::in_item_t cmd,
  output vce_pkg::ctl_t     ctl
);
  import vce_pkg::*;

  state_e     state_r, state_nxt;
  in_item_t   cmd_r, cmd_nxt;
  cnt_t       left_r, left_nxt;
  cnt_t       idx_r, idx_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;
  logic [1:0] size_w;
  logic [1:0] last_w;
  cnt_t       first_w, second_w, dest_w, mat_off_w;

  assign size_w    = (cmd_r.operation == OP_MV3) ? 2'(LARGE_MAT_SIZE) : 2'(SMALL_MAT_SIZE);
  assign last_w    = size_w - 2'd1;
  assign first_w   = CNT_W'(cmd_r.first_source);
  assign second_w  = CNT_W'(cmd_r.second_source);
  assign dest_w    = CNT_W'(cmd_r.destination);
  assign mat_off_w = CNT_W'(last_w) - CNT_W'(row_r) + CNT_W'(col_r);

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    left_nxt  = left_r;
    idx_nxt   = idx_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt  = in_item;
          left_nxt = in_item.element_count;
          idx_nxt  = '0;
          row_nxt  = '0;
          col_nxt  = '0;
          unique case (in_item.operation)
            OP_ADD, OP_SUB: begin
              if (in_item.right_to_left) begin
                idx_nxt = in_item.element_count - CNT_W'(1);
              end
              state_nxt = (in_item.element_count == '0) ? S_DONE : S_EW_RDA;
            end
            OP_MV2, OP_MV3: state_nxt = S_CP_RD;
            OP_WRITE:       state_nxt = S_WORD_WR;
            OP_READ:        state_nxt = S_WORD_RD;
            default:        state_nxt = S_DONE;
          endcase
        end
      end
      S_EW_RDA: state_nxt = S_EW_RDB;
      S_EW_RDB: state_nxt = S_EW_WR;
      S_EW_WR: begin
        left_nxt = left_r - CNT_W'(1);
        idx_nxt  = cmd_r.right_to_left ? idx_r - CNT_W'(1) : idx_r + CNT_W'(1);
        state_nxt = (left_r == CNT_W'(1)) ? S_DONE : S_EW_RDA;
      end
      S_CP_RD: state_nxt = S_CP_WR;
      S_CP_WR: begin
        if (idx_r == CNT_W'(last_w)) begin
          state_nxt = S_MV_RDM;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_CP_RD;
        end
      end
      S_MV_RDM: state_nxt = S_MV_RDA;
      S_MV_RDA: state_nxt = S_MV_WR;
      S_MV_WR: begin
        if (col_r == last_w) begin
          col_nxt = '0;
          if (row_r == last_w) begin
            state_nxt = S_DONE;
          end else begin
            row_nxt   = row_r + 2'd1;
            state_nxt = S_MV_RDM;
          end
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = S_MV_RDM;
        end
      end
      S_WORD_WR: state_nxt = S_DONE;
      S_WORD_RD: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl             = '0;
    ctl.wsel        = WSEL_ZERO;
    ctl.out_is_read = (cmd_r.operation == OP_READ);
    in_stall        = (state_r != S_IDLE);
    unique case (state_r)
      S_EW_RDA: begin
        ctl.re    = 1'b1;
        ctl.raddr = wrap_addr(first_w, idx_r);
      end
      S_EW_RDB: begin
        ctl.re     = 1'b1;
        ctl.raddr  = wrap_addr(second_w, idx_r);
        ctl.cap_op = 1'b1;
      end
      S_EW_WR: begin
        ctl.we    = 1'b1;
        ctl.waddr = wrap_addr(dest_w, idx_r);
        ctl.wsel  = (cmd_r.operation == OP_SUB) ? WSEL_DIFF : WSEL_SUM;
      end
      S_CP_RD: begin
        ctl.re    = 1'b1;
        ctl.raddr = wrap_addr(second_w, idx_r);
      end
      S_CP_WR: begin
        ctl.we        = 1'b1;
        ctl.waddr     = wrap_addr(dest_w, idx_r);
        ctl.wsel      = WSEL_ZERO;
        ctl.cap_vcopy = 1'b1;
        ctl.vidx      = VIDX_W'(idx_r);
      end
      S_MV_RDM: begin
        ctl.re    = 1'b1;
        ctl.raddr = wrap_addr(first_w, mat_off_w);
      end
      S_MV_RDA: begin
        ctl.re      = 1'b1;
        ctl.raddr   = wrap_addr(dest_w, CNT_W'(row_r));
        ctl.cap_op  = 1'b1;
        ctl.use_mul = 1'b1;
        ctl.vidx    = VIDX_W'(col_r);
      end
      S_MV_WR: begin
        ctl.we    = 1'b1;
        ctl.waddr = wrap_addr(dest_w, CNT_W'(row_r));
        ctl.wsel  = WSEL_MACC;
      end
      S_WORD_WR: begin
        ctl.we    = 1'b1;
        ctl.waddr = wrap_addr(dest_w, '0);
        ctl.wsel  = WSEL_WORD;
      end
      S_WORD_RD: begin
        ctl.re    = 1'b1;
        ctl.raddr = wrap_addr(dest_w, '0);
      end
      S_DONE: begin
        ctl.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    left_r <= left_nxt;
    idx_r  <= idx_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
  end

  assign cmd = cmd_r;

endmodule

FILE: hw/rtl/vce_dp.sv
// datapath: operand/product register, vector copy, write data select
// depends on vce_pkg
module vce_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vce_pkg::ctl_t              ctl,
  input  logic [vce_pkg::VALUE_W-1:0] write_value,
  input  vce_pkg::word_t             rdata,
  output vce_pkg::word_t             wdata
);
  import vce_pkg::*;

  word_t opa_r;
  word_t vcopy_r [VCOPY_DEPTH];
  word_t prod_w;

  assign prod_w = word_t'(rdata * vcopy_r[ctl.vidx]);

  always_ff @(posedge clk) begin
    if (ctl.cap_op) begin
      opa_r <= ctl.use_mul ? prod_w : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VCOPY_DEPTH; i++) begin
        vcopy_r[i] <= '0;
      end
    end else if (ctl.cap_vcopy) begin
      vcopy_r[ctl.vidx] <= rdata;
    end
  end

  always_comb begin
    unique case (ctl.wsel)
      WSEL_SUM:  wdata = opa_r + rdata;
      WSEL_DIFF: wdata = opa_r - rdata;
      WSEL_MACC: wdata = rdata + opa_r;
      WSEL_WORD: wdata = word_t'(write_value);
      default:   wdata = '0;
    endcase
  end

endmodule

FILE: sim/tb_top.sv
// testbench for vector_command_executor_core: directed and random commands
// are checked against a memory image kept in step with every accepted item
// depends on vce_pkg and the rtl of the core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vce_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_CMDS = 268;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  in_item_t  command_queue[$];
  out_item_t expected_replies[$];
  word_t     mem_image [MEM_DEPTH];
  word_t     vec_latch [VCOPY_DEPTH];
  int        total_cmds = 0;
  int        accepted_cmds = 0;
  int        fail_count = 0;
  logic      in_taken = 1'b0;

  vector_command_executor_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  function automatic in_item_t make_cmd(input logic [2:0] op, input logic rtl, input int cnt,
                                        input int s0, input int s1, input int d,
                                        input word_t wv);
    in_item_t c;
    c.operation     = op;
    c.right_to_left = rtl;
    c.element_count = CNT_W'(cnt);
    c.first_source  = FADDR_W'(s0);
    c.second_source = FADDR_W'(s1);
    c.destination   = FADDR_W'(d);
    c.write_value   = wv;
    return c;
  endfunction

  function automatic out_item_t execute_command(input in_item_t c);
    out_item_t r;
    int        n, k, idx, sz, row, col;
    word_t     a, b;
    r = '0;
    case (c.operation)
      OP_ADD, OP_SUB: begin
        n = int'(c.element_count);
        for (k = 0; k < n; k++) begin
          idx = c.right_to_left ? n - 1 - k : k;
          a = mem_image[addr_t'(c.first_source + idx)];
          b = mem_image[addr_t'(c.second_source + idx)];
          if (c.operation == OP_SUB) begin
            mem_image[addr_t'(c.destination + idx)] = a - b;
          end else begin
            mem_image[addr_t'(c.destination + idx)] = a + b;
          end
        end
      end
      OP_MV2, OP_MV3: begin
        sz = (c.operation == OP_MV2) ? SMALL_MAT_SIZE : LARGE_MAT_SIZE;
        for (k = 0; k < sz; k++) begin
          vec_latch[k] = mem_image[addr_t'(c.second_source + k)];
          mem_image[addr_t'(c.destination + k)] = '0;
        end
        for (row = 0; row < sz; row++) begin
          for (col = 0; col < sz; col++) begin
            a = mem_image[addr_t'(c.first_source + sz - 1 - row + col)];
            b = a * vec_latch[col];
            mem_image[addr_t'(c.destination + row)] =
              mem_image[addr_t'(c.destination + row)] + b;
          end
        end
      end
      OP_WRITE: mem_image[c.destination] = c.write_value;
      OP_READ: begin
        r.read_value = mem_image[c.destination];
        r.was_read   = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int idle_pct(input bit receiver);
    if (accepted_cmds < total_cmds / 3) return receiver ? 82 : 26;
    if (accepted_cmds < 2 * total_cmds / 3) return receiver ? 26 : 82;
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      if (rst_n && command_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        in_item  <= command_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < idle_pct(1'b1));
  end

  always @(posedge clk) begin : observe
    out_item_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(execute_command(in_item));
        accepted_cmds <= accepted_cmds + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_replies.pop_front();
          if (out_item.read_value !== want.read_value) begin
            report_mismatch($sformatf("read_value got %h want %h",
                                      out_item.read_value, want.read_value));
          end
          if (out_item.was_read !== want.was_read) begin
            report_mismatch($sformatf("was_read got %b want %b",
                                      out_item.was_read, want.was_read));
          end
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t c;
    int       i, pick;
    // seed two words, then an overlapping add fills the rest of memory
    command_queue.push_back(make_cmd(OP_WRITE, 1'b0, 0, 0, 0, 0, 32'h0000_0001));
    command_queue.push_back(make_cmd(OP_WRITE, 1'b0, 0, 0, 0, 1, 32'h0000_0001));
    command_queue.push_back(make_cmd(OP_ADD, 1'b0, 1022, 1, 0, 2, '0));
    command_queue.push_back(make_cmd(OP_READ, 1'b0, 0, 0, 0, 1023, '0));
    command_queue.push_back(make_cmd(OP_WRITE, 1'b1, 1024, 1023, 1023, 1023, 32'hFFFF_FFFF));
    command_queue.push_back(make_cmd(OP_WRITE, 1'b0, 0, 0, 0, 5, 32'h0000_0000));
    command_queue.push_back(make_cmd(OP_READ, 1'b0, 0, 0, 0, 0, '0));
    command_queue.push_back(make_cmd(OP_READ, 1'b1, 0, 0, 0, 1023, '0));
    command_queue.push_back(make_cmd(OP_ADD, 1'b0, 0, 10, 20, 30, '0));
    command_queue.push_back(make_cmd(OP_SUB, 1'b1, 1024, 1023, 517, 100, '0));
    command_queue.push_back(make_cmd(OP_ADD, 1'b0, 1024, 0, 1023, 1023, '0));
    command_queue.push_back(make_cmd(OP_SUB, 1'b1, 7, 200, 300, 198, '0));
    command_queue.push_back(make_cmd(OP_ADD, 1'b1, 9, 400, 400, 401, '0));
    command_queue.push_back(make_cmd(OP_MV2, 1'b0, 0, 1023, 10, 20, '0));
    command_queue.push_back(make_cmd(OP_MV3, 1'b0, 0, 30, 38, 39, '0));
    command_queue.push_back(make_cmd(OP_MV3, 1'b1, 0, 50, 60, 51, '0));
    command_queue.push_back(make_cmd(OP_MV3, 1'b0, 0, 1022, 1021, 1023, '0));
    command_queue.push_back(make_cmd(OP_MV2, 1'b0, 0, 80, 70, 70, '0));
    command_queue.push_back(make_cmd(OP_SPARE_6, 1'b1, 5, 1, 2, 3, 32'hDEAD_BEEF));
    command_queue.push_back(make_cmd(OP_SPARE_7, 1'b0, 5, 1, 2, 3, 32'h1234_5678));
    command_queue.push_back(make_cmd(OP_READ, 1'b0, 0, 0, 0, 20, '0));
    command_queue.push_back(make_cmd(OP_READ, 1'b0, 0, 0, 0, 39, '0));
    command_queue.push_back(make_cmd(OP_READ, 1'b0, 0, 0, 0, 51, '0));
    command_queue.push_back(make_cmd(OP_READ, 1'b0, 0, 0, 0, 1, '0));

    for (i = 0; i < RANDOM_CMDS; i++) begin
      c.operation     = OP_READ;
      c.right_to_left = 1'($urandom_range(1));
      c.element_count = CNT_W'($urandom_range(1024));
      c.first_source  = FADDR_W'($urandom_range(1023));
      c.second_source = FADDR_W'($urandom_range(1023));
      c.destination   = FADDR_W'($urandom_range(1023));
      c.write_value   = $urandom;
      pick = $urandom_range(99);
      if (pick < 34) begin
        c.operation = pick[0] ? OP_SUB : OP_ADD;
        if (pick >= 8) begin
          c.element_count = CNT_W'($urandom_range(12));
        end else if (pick >= 2) begin
          c.element_count = CNT_W'($urandom_range(64));
        end
      end else if (pick < 54) begin
        c.operation = pick[0] ? OP_MV3 : OP_MV2;
      end else if (pick < 74) begin
        c.operation = OP_WRITE;
      end else if (pick < 94) begin
        c.operation = OP_READ;
      end else if (pick < 97) begin
        c.operation = OP_SPARE_6;
      end else begin
        c.operation = OP_SPARE_7;
      end
      command_queue.push_back(c);
    end
    total_cmds = command_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (command_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
